// ===== rtl/core/sjfq_pkg.sv =====
// Package for the shortest-job-first queue.
// Holds the field widths, command and status codes, and the cell entry and control types.
// No dependencies.
`timescale 1ns / 1ps

package sjfq_pkg;

  // Field widths of the input and result beats.
  localparam int unsigned LenW   = 31;
  localparam int unsigned TagW   = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  // Default number of queue cells.
  localparam int unsigned QueueDepthDefault = 16;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // Status codes.
  localparam logic [StatW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd2;

  // Contents of one queue cell.
  typedef struct packed {
    logic            valid;
    logic [LenW-1:0] len;
    logic [TagW-1:0] tag;
  } entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic            ins;
    logic            pop;
    logic [LenW-1:0] len;
    logic [TagW-1:0] tag;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sjfq_if.sv =====
// Handshake channels of the shortest-job-first queue.
// Depends on sjfq_pkg for the field widths.
`timescale 1ns / 1ps

// Input channel: one insert or pop command per beat.
interface sjfq_in_if import sjfq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [LenW-1:0] job_length;
  logic [TagW-1:0] job_tag;

  modport source (output valid, cmd, job_length, job_tag, input ready);
  modport sink   (input valid, cmd, job_length, job_tag, output ready);
endinterface

// Result channel: one result beat per command.
interface sjfq_out_if import sjfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic              popped_valid;
  logic [LenW-1:0]   popped_length;
  logic [TagW-1:0]   popped_tag;
  logic [CountW-1:0] job_count;

  modport source (output valid, status, popped_valid, popped_length, popped_tag,
                  job_count, input ready);
  modport sink   (input valid, status, popped_valid, popped_length, popped_tag,
                  job_count, output ready);
endinterface

// ===== rtl/core/sjfq_cell.sv =====
// One cell of the sorted queue chain.
// Depends on sjfq_pkg for the entry and control types.
`timescale 1ns / 1ps

module sjfq_cell import sjfq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     left_i,
  input  logic       left_gt_i,
  input  entry_t     right_i,
  output entry_t     entry_o,
  output logic       gt_o
);

  entry_t          entry_q, entry_d;
  logic            valid_q;
  logic [LenW-1:0] len_q;
  logic [TagW-1:0] tag_q;

  // Current contents assembled from the separately clocked registers.
  assign entry_q = {valid_q, len_q, tag_q};

  // The new job belongs in front of this cell when the cell is empty or
  // holds a strictly longer job; equal lengths stay ahead of the new job.
  assign gt_o = !entry_q.valid || (entry_q.len > ctrl_i.len);

  // Insert: shift right from the left neighbor, or take the new job at the
  // boundary. Pop: shift left from the right neighbor.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else begin
        entry_d.valid = 1'b1;
        entry_d.len   = ctrl_i.len;
        entry_d.tag   = ctrl_i.tag;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    len_q <= entry_d.len;
    tag_q <= entry_d.tag;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/core/shortest_job_first_queue.sv =====
// Top level of the shortest-job-first queue: a chain of sorted cells and a
// registered result stage. Depends on sjfq_pkg, sjfq_if and sjfq_cell.
//
//  Channel | Dir | Beat contents
//  in_i    | in  | cmd, job_length, job_tag
//  out_o   | out | status, popped_valid, popped_length, popped_tag, job_count
//
// For each command, every cell compares its key with the new length in
// parallel and moves one place in the same cycle, so a new beat is accepted
// every cycle while the result register is free or being drained.
// The result is registered and appears in the cycle after its command is accepted.
// Reset clears all cell valid bits and the count; the queue is empty after it.
// A stalled result holds the input off until it is taken.
`timescale 1ns / 1ps

module shortest_job_first_queue import sjfq_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sjfq_in_if.sink       in_i,
  sjfq_out_if.source    out_o
);

  localparam int unsigned OccW = $clog2(QueueDepth + 1);

  entry_t                 cells   [QueueDepth];
  logic   [QueueDepth-1:0] gt;
  cell_ctrl_t             ctrl;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic   [OccW-1:0]      occ_q, occ_d;
  logic   [OccW+CountW-1:0] occ_wide;
  entry_t                 no_entry;

  // Result register.
  logic              res_valid_q;
  logic [StatW-1:0]  status_q, status_d;
  logic              pv_q, pv_d;
  logic [LenW-1:0]   plen_q, plen_d;
  logic [TagW-1:0]   ptag_q, ptag_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  // Input is taken whenever the result register is free or drains this cycle.
  assign in_i.ready = !res_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign full  = cells[QueueDepth-1].valid;
  assign empty = !cells[0].valid;

  // Operation broadcast to the chain.
  always_comb begin
    ctrl.ins = accept && (in_i.cmd == CMD_INSERT) && !full;
    ctrl.pop = accept && (in_i.cmd == CMD_POP) && !empty;
    ctrl.len = in_i.job_length;
    ctrl.tag = in_i.job_tag;
  end

  assign no_entry = '0;

  // Chain of cells, each linked to both neighbors.
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_gt;

    if (i == 0) begin : g_head
      assign left_e  = no_entry;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = cells[i-1];
      assign left_gt = gt[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_e = no_entry;
    end else begin : g_body
      assign right_e = cells[i+1];
    end

    sjfq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .entry_o   (cells[i]),
      .gt_o      (gt[i])
    );
  end

  // Occupancy count.
  always_comb begin
    occ_d = occ_q;
    if (ctrl.ins) begin
      occ_d = occ_q + OccW'(1);
    end else if (ctrl.pop) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  assign occ_wide = {{CountW{1'b0}}, occ_d};

  // Result of the accepted command.
  always_comb begin
    status_d = ST_DONE;
    pv_d     = 1'b0;
    plen_d   = '0;
    ptag_d   = '0;
    if (in_i.cmd == CMD_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        pv_d   = 1'b1;
        plen_d = cells[0].len;
        ptag_d = cells[0].tag;
      end
    end
    cnt_d = occ_wide[CountW-1:0];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pv_q     <= pv_d;
      plen_q   <= plen_d;
      ptag_q   <= ptag_d;
      cnt_q    <= cnt_d;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.status        = status_q;
  assign out_o.popped_valid  = pv_q;
  assign out_o.popped_length = plen_q;
  assign out_o.popped_tag    = ptag_q;
  assign out_o.job_count     = cnt_q;

endmodule

// ===== tb/sv/tb_shortest_job_first_queue.sv =====
// Self-checking testbench for the shortest-job-first queue.
// Depends on sjfq_pkg, the sjfq_in_if and sjfq_out_if channels, and the
// shortest_job_first_queue top level.
`timescale 1ns / 1ps

module tb_shortest_job_first_queue;
  import sjfq_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = QueueDepthDefault;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_BEATS   = 200;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [LenW-1:0] LEN_MAX   = {LenW{1'b1}};

  // Traffic shapes of the random phases.
  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_e;

  // One result beat as the queue should present it.
  typedef struct packed {
    logic [StatW-1:0]  status;
    logic              popped_valid;
    logic [LenW-1:0]   popped_length;
    logic [TagW-1:0]   popped_tag;
    logic [CountW-1:0] job_count;
  } job_result_t;

  // Sorted job store mirrored in software, plus the results still owed.
  class sjf_scoreboard;
    logic [LenW-1:0] key_mem [QUEUE_DEPTH];
    logic [TagW-1:0] tag_mem [QUEUE_DEPTH];
    int unsigned     jobs_held;
    job_result_t     owed_results [$];
    int unsigned     errors, checked, inserts, rejects, pops, empty_pops, peak;

    function new();
      jobs_held  = 0;
      errors     = 0;
      checked    = 0;
      inserts    = 0;
      rejects    = 0;
      pops       = 0;
      empty_pops = 0;
      peak       = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Applies one accepted command to the mirror and records its result.
    function void note_command(logic cmd, logic [LenW-1:0] len, logic [TagW-1:0] tag);
      job_result_t r;
      int unsigned slot;
      int unsigned i;
      r = '0;
      if (cmd == CMD_INSERT) begin
        inserts++;
        if (jobs_held >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          rejects++;
        end else begin
          // A new job lands behind every stored job of equal or smaller length.
          slot = 0;
          while (slot < jobs_held && key_mem[slot] <= len) slot++;
          for (i = jobs_held; i > slot; i--) begin
            key_mem[i] = key_mem[i-1];
            tag_mem[i] = tag_mem[i-1];
          end
          key_mem[slot] = len;
          tag_mem[slot] = tag;
          jobs_held++;
          r.status = ST_DONE;
        end
      end else begin
        pops++;
        if (jobs_held == 0) begin
          r.status = ST_EMPTY;
          empty_pops++;
        end else begin
          r.status        = ST_DONE;
          r.popped_valid  = 1'b1;
          r.popped_length = key_mem[0];
          r.popped_tag    = tag_mem[0];
          for (i = 0; i + 1 < jobs_held; i++) begin
            key_mem[i] = key_mem[i+1];
            tag_mem[i] = tag_mem[i+1];
          end
          jobs_held--;
        end
      end
      if (jobs_held > peak) peak = jobs_held;
      r.job_count = jobs_held[CountW-1:0];
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // Compares one result beat with the oldest owed result.
    function void check_result(logic [StatW-1:0] status, logic popped_valid,
                               logic [LenW-1:0] popped_length, logic [TagW-1:0] popped_tag,
                               logic [CountW-1:0] job_count);
      job_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, actual status %0d count %0d",
                 $time, status, job_count);
        return;
      end
      want = owed_results.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("popped_valid", 32'(want.popped_valid), 32'(popped_valid));
      compare_field("popped_length", 32'(want.popped_length), 32'(popped_length));
      compare_field("popped_tag", 32'(want.popped_tag), 32'(popped_tag));
      compare_field("job_count", 32'(want.job_count), 32'(job_count));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        hold_results = 1'b0;
  logic        steady_flow  = 1'b0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  sjf_scoreboard sb;

  sjfq_in_if  in_if ();
  sjfq_out_if out_if ();

  shortest_job_first_queue #(
    .QueueDepth(QUEUE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock with a 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_shortest_job_first_queue: errors");
      $finish;
    end
  end

  // Result side: random short and long stalls, one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_results) begin
        stall_left = HOLD_CYCLES - 1;
        hold_results <= 1'b0;
        out_if.ready <= 1'b0;
      end else if (steady_flow) begin
        out_if.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:64]:  out_if.ready <= 1'b1;
          [65:89]: begin
            stall_left = $urandom_range(0, 2);
            out_if.ready <= 1'b0;
          end
          default: begin
            stall_left = $urandom_range(7, 39);
            out_if.ready <= 1'b0;
          end
        endcase
      end
    end
  end

  // Every accepted result beat is checked against the mirror.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_result(out_if.status, out_if.popped_valid, out_if.popped_length,
                      out_if.popped_tag, out_if.job_count);
    end
  end

  // Offers one command beat after an idle gap and waits until it is taken.
  // Called and returns at a falling edge.
  task automatic send_beat(logic cmd, logic [LenW-1:0] len, logic [TagW-1:0] tag,
                           int unsigned gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.job_length <= len;
    in_if.job_tag    <= tag;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_command(cmd, len, tag);
    @(negedge clk_i);
  endtask

  // Stops offering beats until every owed result has come back.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Lengths lean on the extremes and on a narrow band that forces ties.
  function automatic logic [LenW-1:0] pick_length();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEN_MAX;
      2:       return LEN_MAX - LenW'($urandom_range(0, 3));
      3, 4, 5: return LenW'($urandom_range(0, 7));
      default: return raw[LenW-1:0];
    endcase
  endfunction

  function automatic logic pick_cmd(traffic_mix_e mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return (roll < 72) ? CMD_INSERT : CMD_POP;
      MIX_DRAIN: return (roll < 72) ? CMD_POP : CMD_INSERT;
      default:   return (roll < 50) ? CMD_INSERT : CMD_POP;
    endcase
  endfunction

  // Stimulus: directed corner beats, then random phases of varying mix.
  initial begin
    traffic_mix_e mix;
    logic [31:0]  raw;
    sb = new();
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_INSERT;
    in_if.job_length = '0;
    in_if.job_tag    = '0;
    rst_ni           = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Pop on an empty queue, the extreme keys, and a run of equal lengths.
    send_beat(CMD_POP, LEN_MAX, 16'hffff, 0);
    send_beat(CMD_INSERT, LEN_MAX, 16'hffff, 0);
    send_beat(CMD_INSERT, '0, 16'h0000, 0);
    send_beat(CMD_INSERT, 31'd5, 16'h1111, 1);
    send_beat(CMD_INSERT, 31'd5, 16'h2222, 0);
    send_beat(CMD_INSERT, 31'd5, 16'h3333, 0);
    send_beat(CMD_INSERT, '0, 16'h4444, 2);
    send_beat(CMD_INSERT, LEN_MAX, 16'h5555, 0);
    repeat (9) send_beat(CMD_POP, '0, '0, 0);
    wait_for_results();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      mix = traffic_mix_e'(phase % 3);
      // The fourth phase starts under a long result hold-off; the fifth runs
      // with no idling on either side.
      if (phase == 3) hold_results <= 1'b1;
      steady_flow <= (phase == 4);
      for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
        raw = $urandom;
        send_beat(pick_cmd(mix), pick_length(), raw[TagW-1:0], pick_gap());
      end
      wait_for_results();
    end

    steady_flow <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Covered %0d inserts (%0d refused on a full queue) and %0d pops (%0d on an empty queue).",
             sb.inserts, sb.rejects, sb.pops, sb.empty_pops);
    $display("Checked %0d result beats, peak occupancy %0d of %0d, %0d mismatches.",
             sb.checked, sb.peak, QUEUE_DEPTH, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_shortest_job_first_queue: clean");
    end else begin
      $display("tb_shortest_job_first_queue: errors");
    end
    $finish;
  end

endmodule
